// ===== rtl/ccl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Charge current limiter package
// Window sizes, gains, widths, register indexes and the stage word type.
// ----------------------------------------------------------------------------
package ccl_pkg;

    localparam int SHORT_WINDOW = 10;
    localparam int LONG_WINDOW  = 100;

    localparam int SHORT_PW = (SHORT_WINDOW > 1) ? $clog2(SHORT_WINDOW) : 1;
    localparam int LONG_PW  = (LONG_WINDOW > 1) ? $clog2(LONG_WINDOW) : 1;

    localparam int VAL_W   = 16;
    localparam int ERR_W   = VAL_W + 1;
    localparam int DELTA_W = ERR_W + 1;

    localparam int KP_Q16    = 13107;
    localparam int KI_Q16    = 9830;
    localparam int KI_SCALED = KI_Q16 * SHORT_WINDOW;

    localparam longint NUM_MAX = longint'(SHORT_WINDOW) * 65535 * KP_Q16
                               + longint'(LONG_WINDOW) * 65535 * KI_SCALED;
    localparam int NUM_W  = $clog2(NUM_MAX + 1) + 2;
    localparam int FRAC_W = 16;
    localparam int QN_W   = NUM_W - FRAC_W;

    localparam int SW_LOG      = $clog2(SHORT_WINDOW);
    localparam int RECIP_SHIFT = QN_W + SW_LOG;
    localparam int RECIP_W     = QN_W + 2;
    localparam longint RECIP_VAL =
        ((longint'(1) << RECIP_SHIFT) + SHORT_WINDOW - 1) / SHORT_WINDOW;
    localparam int PROD_W = RECIP_SHIFT + QN_W;
    localparam int DRV_W  = QN_W + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_TARGET_MA   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SETPOINT_MV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_OUTPUT_MV      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MARGIN_MA  = 3'd4;

    localparam logic [VAL_W-1:0] RELEASE_MARGIN_RESET = 16'd200;

    typedef struct packed {
        logic                    limiting;
        logic                    drive_valid;
        logic                    upper;
        logic signed [NUM_W-1:0] num;
    } ccl_step_t;

endpackage
`default_nettype wire

// ===== rtl/ccl_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one measured current word.
// ----------------------------------------------------------------------------
interface ccl_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] measured_current_ma;

    modport source (output valid, output measured_current_ma, input ready);
    modport sink (input valid, input measured_current_ma, output ready);
endinterface
`default_nettype wire

// ===== rtl/ccl_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one limiter result word.
// ----------------------------------------------------------------------------
interface ccl_result_if;
    logic        valid;
    logic        ready;
    logic        limiting;
    logic        drive_valid;
    logic [15:0] drive_mv;

    modport source (output valid, output limiting, output drive_valid, output drive_mv,
                    input ready);
    modport sink (input valid, input limiting, input drive_valid, input drive_mv,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/charge_current_limit_pi.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Charge current limiter
// PI-style current limiter with a short moving-average error window and a
// long sliding-sum error window driving an output voltage command.
// ----------------------------------------------------------------------------
// An accepted sample is held in the sample register, then passes the drive stage's
// step word and quotient registers to its result word in the clamp (output) register.
// One sample is accepted every cycle when results are taken. The rate is
// set by the window update, which carries the weighted error sum as one
// running accumulator. Reset returns all control state and the configuration to
// its reset values (release margin 200 mA); the error rings need no clearing pass.
module charge_current_limit_pi (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ccl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ccl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    ccl_sample_if.sink                          sample_in,
    ccl_result_if.source                        result_out
);
    import ccl_pkg::*;

    localparam logic signed [NUM_W-1:0] KP_N = NUM_W'(KP_Q16);
    localparam logic signed [NUM_W-1:0] KI_N = NUM_W'(KI_SCALED);
    localparam logic [SHORT_PW-1:0] SHORT_LAST = SHORT_PW'(SHORT_WINDOW - 1);
    localparam logic [LONG_PW-1:0]  LONG_LAST  = LONG_PW'(LONG_WINDOW - 1);

    logic             control_enable_reg;
    logic [VAL_W-1:0] charge_target_reg;
    logic [VAL_W-1:0] setpoint_reg;
    logic [VAL_W-1:0] min_output_reg;
    logic [VAL_W-1:0] release_margin_reg;

    logic             s0_valid_reg;
    logic [VAL_W-1:0] s0_meas_reg;

    logic signed [ERR_W-1:0] short_ring_reg [SHORT_WINDOW];
    logic signed [ERR_W-1:0] long_ring_mem [LONG_WINDOW];
    logic signed [ERR_W-1:0] long_rd_reg;
    logic signed [ERR_W-1:0] long_wdata_reg;
    logic                    long_byp_reg;

    logic signed [NUM_W-1:0] num_reg, num_next;
    logic [SHORT_PW-1:0]     short_pos_reg, short_pos_next;
    logic [LONG_PW-1:0]      long_pos_reg, long_pos_next;
    logic                    short_full_reg, short_full_next;
    logic                    long_full_reg, long_full_next;
    logic                    unclamped_last_reg, unclamped_last_next;
    logic                    limit_active_reg, limit_active_next;

    logic                    stage_ready;
    logic                    s0_fire;
    logic                    take;
    logic                    release_hit;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] short_old;
    logic signed [ERR_W-1:0] long_old;
    logic signed [DELTA_W-1:0] delta_s;
    logic signed [DELTA_W-1:0] delta_l;
    logic signed [NUM_W-1:0] num_step;
    logic                    short_full_new;
    logic                    long_full_new;
    ccl_step_t               step_word;

    logic             res_valid;
    logic             res_limiting;
    logic             res_drive_valid;
    logic [VAL_W-1:0] res_drive_mv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_enable_reg <= 1'b0;
            charge_target_reg  <= '0;
            setpoint_reg       <= '0;
            min_output_reg     <= '0;
            release_margin_reg <= RELEASE_MARGIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CONTROL_ENABLE:     control_enable_reg <= cfg_wdata[0];
                REG_CHARGE_TARGET_MA:   charge_target_reg  <= cfg_wdata[VAL_W-1:0];
                REG_OUTPUT_SETPOINT_MV: setpoint_reg       <= cfg_wdata[VAL_W-1:0];
                REG_MIN_OUTPUT_MV:      min_output_reg     <= cfg_wdata[VAL_W-1:0];
                REG_RELEASE_MARGIN_MA:  release_margin_reg <= cfg_wdata[VAL_W-1:0];
                default:                ;
            endcase
        end
    end

    assign sample_in.ready = !s0_valid_reg || stage_ready;
    assign s0_fire         = s0_valid_reg && stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (sample_in.ready)
        begin
            s0_valid_reg <= sample_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_in.ready && sample_in.valid)
        begin
            s0_meas_reg <= sample_in.measured_current_ma;
        end
    end

    assign err = signed'({1'b0, charge_target_reg}) - signed'({1'b0, s0_meas_reg});
    assign release_hit = unclamped_last_reg
                      && (err > signed'({1'b0, release_margin_reg}));
    assign take = s0_fire && control_enable_reg && !release_hit;

    assign short_old = short_ring_reg[short_pos_reg];
    assign long_old  = long_byp_reg ? long_wdata_reg : long_rd_reg;

    assign delta_s = DELTA_W'(err) - (short_full_reg ? DELTA_W'(short_old) : '0);
    assign delta_l = DELTA_W'(err) - (long_full_reg ? DELTA_W'(long_old) : '0);
    assign num_step = num_reg + NUM_W'(delta_s) * KP_N + NUM_W'(delta_l) * KI_N;

    assign short_full_new = short_full_reg || (short_pos_reg == SHORT_LAST);
    assign long_full_new  = long_full_reg || (long_pos_reg == LONG_LAST);

    always_comb
    begin
        num_next            = num_reg;
        short_pos_next      = short_pos_reg;
        long_pos_next       = long_pos_reg;
        short_full_next     = short_full_reg;
        long_full_next      = long_full_reg;
        unclamped_last_next = unclamped_last_reg;
        limit_active_next   = limit_active_reg;
        if (s0_fire && control_enable_reg)
        begin
            if (release_hit)
            begin
                num_next          = '0;
                short_pos_next    = '0;
                long_pos_next     = '0;
                short_full_next   = 1'b0;
                long_full_next    = 1'b0;
                limit_active_next = 1'b0;
            end
            else
            begin
                num_next          = num_step;
                limit_active_next = 1'b1;
                short_full_next   = short_full_new;
                long_full_next    = long_full_new;
                short_pos_next    = (short_pos_reg == SHORT_LAST) ? '0
                                  : short_pos_reg + SHORT_PW'(1);
                long_pos_next     = (long_pos_reg == LONG_LAST) ? '0
                                  : long_pos_reg + LONG_PW'(1);
                if (short_full_new && long_full_new)
                begin
                    unclamped_last_next = !num_step[NUM_W-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg            <= '0;
            short_pos_reg      <= '0;
            long_pos_reg       <= '0;
            short_full_reg     <= 1'b0;
            long_full_reg      <= 1'b0;
            unclamped_last_reg <= 1'b1;
            limit_active_reg   <= 1'b0;
            long_byp_reg       <= 1'b0;
        end
        else
        begin
            num_reg            <= num_next;
            short_pos_reg      <= short_pos_next;
            long_pos_reg       <= long_pos_next;
            short_full_reg     <= short_full_next;
            long_full_reg      <= long_full_next;
            unclamped_last_reg <= unclamped_last_next;
            limit_active_reg   <= limit_active_next;
            long_byp_reg       <= take && (long_pos_reg == long_pos_next);
        end
    end

    // The long ring is read into a register at the position the next sample will use.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            long_ring_mem[long_pos_reg]  <= err;
            short_ring_reg[short_pos_reg] <= err;
        end
        long_rd_reg    <= long_ring_mem[long_pos_next];
        long_wdata_reg <= err;
    end

    always_comb
    begin
        step_word.limiting    = control_enable_reg ? !release_hit : limit_active_reg;
        step_word.drive_valid = take && short_full_new && long_full_new;
        step_word.upper       = !num_step[NUM_W-1];
        step_word.num         = num_step;
    end

    ccl_drive_stage u_drive_stage (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s0_valid_reg),
        .in_ready        (stage_ready),
        .in_word         (step_word),
        .setpoint        (setpoint_reg),
        .min_output      (min_output_reg),
        .out_valid       (res_valid),
        .out_ready       (result_out.ready),
        .out_limiting    (res_limiting),
        .out_drive_valid (res_drive_valid),
        .out_drive_mv    (res_drive_mv)
    );

    assign result_out.valid       = res_valid;
    assign result_out.limiting    = res_limiting;
    assign result_out.drive_valid = res_drive_valid;
    assign result_out.drive_mv    = res_drive_mv;

    a_drive_needs_limiting: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && res_drive_valid |-> res_limiting)
        else $error("Drive commanded while limiting is off.");

    a_idle_drive_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && !res_drive_valid |-> res_drive_mv == '0)
        else $error("Drive voltage is nonzero without a command.");

    a_state_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s0_fire |=> $stable(num_reg) && $stable(limit_active_reg)
                     && $stable(unclamped_last_reg))
        else $error("Controller state changed without a sample.");

    a_release_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        s0_fire && control_enable_reg && release_hit
        |=> num_reg == '0 && !short_full_reg && !long_full_reg)
        else $error("Windows not cleared on release.");

endmodule
`default_nettype wire

// ===== rtl/ccl_drive_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drive stage
// Three registered stages: step word, floor division by reciprocal, clamp.
// ----------------------------------------------------------------------------
module ccl_drive_stage (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire ccl_pkg::ccl_step_t        in_word,
    input  wire logic [ccl_pkg::VAL_W-1:0] setpoint,
    input  wire logic [ccl_pkg::VAL_W-1:0] min_output,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           out_limiting,
    output logic                           out_drive_valid,
    output logic [ccl_pkg::VAL_W-1:0]      out_drive_mv
);
    import ccl_pkg::*;

    localparam logic [PROD_W-1:0] RECIP = PROD_W'(RECIP_VAL);

    ccl_step_t s1_word_reg;
    logic      s1_valid_reg;

    logic              s2_valid_reg;
    logic              s2_limiting_reg;
    logic              s2_drive_valid_reg;
    logic              s2_upper_reg;
    logic [QN_W-1:0]   s2_quot_reg;

    logic              s3_valid_reg;
    logic              s3_limiting_reg;
    logic              s3_drive_valid_reg;
    logic [VAL_W-1:0]  s3_drive_reg;

    logic              s1_ready;
    logic              s2_ready;
    logic              s3_ready;
    logic [QN_W-1:0]   dividend;
    logic [PROD_W-1:0] product;
    logic [QN_W-1:0]   quot;
    logic signed [DRV_W-1:0] lowered;
    logic [VAL_W-1:0]  drive_next;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // For a negative numerator, floor(num / (W * 2^16)) equals ~(~(num >>> 16) / W).
    assign dividend = ~s1_word_reg.num[NUM_W-1:FRAC_W];
    assign product  = PROD_W'(dividend) * RECIP;
    assign quot     = product[RECIP_SHIFT +: QN_W];

    always_comb
    begin
        lowered = signed'(DRV_W'(setpoint)) - signed'(DRV_W'(s2_quot_reg))
                - signed'(DRV_W'(1));
        if (!s2_drive_valid_reg)
        begin
            drive_next = '0;
        end
        else if (s2_upper_reg)
        begin
            drive_next = setpoint;
        end
        else if (lowered < signed'(DRV_W'(min_output)))
        begin
            drive_next = min_output;
        end
        else
        begin
            drive_next = lowered[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_word_reg <= in_word;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_limiting_reg    <= s1_word_reg.limiting;
            s2_drive_valid_reg <= s1_word_reg.drive_valid;
            s2_upper_reg       <= s1_word_reg.upper;
            s2_quot_reg        <= quot;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_limiting_reg    <= s2_limiting_reg;
            s3_drive_valid_reg <= s2_drive_valid_reg;
            s3_drive_reg       <= drive_next;
        end
    end

    assign out_valid       = s3_valid_reg;
    assign out_limiting    = s3_limiting_reg;
    assign out_drive_valid = s3_drive_valid_reg;
    assign out_drive_mv    = s3_drive_reg;

endmodule
`default_nettype wire

// ===== tb/sv/charge_current_limit_pi_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Charge current limiter testbench
// Drives current sample words through the limiter under several register
// settings and idle/stall mixes, predicts every result word from its own copy
// of the error windows, and compares each result word field by field.
// ----------------------------------------------------------------------------
module charge_current_limit_pi_tb;
    import ccl_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 140;
    localparam int SHORT_DEPTH     = 10;
    localparam int LONG_DEPTH      = 100;
    localparam int GAIN_P          = 13107;
    localparam int GAIN_I          = 9830;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    typedef struct packed {
        logic        limiting;
        logic        drive_valid;
        logic [15:0] drive_mv;
    } limiter_word_t;

    class limiter_scoreboard;
        bit                 enable;
        logic [15:0]        target;
        logic [15:0]        setpoint;
        logic [15:0]        floor_mv;
        logic [15:0]        margin;
        logic signed [16:0] short_err [SHORT_DEPTH];
        logic signed [16:0] long_err [LONG_DEPTH];
        logic signed [20:0] short_total;
        logic signed [23:0] long_total;
        int                 short_idx;
        int                 long_idx;
        bit                 short_ready;
        bit                 long_ready;
        bit                 unclamped;
        bit                 limit_on;
        limiter_word_t      expected_words [$];
        int                 mismatches;
        int                 samples;
        int                 words_checked;
        int                 drives;
        int                 releases;
        int                 upper_clamps;
        int                 lower_clamps;
        int                 floor_hits;

        function new();
            enable    = 1'b0;
            target    = '0;
            setpoint  = '0;
            floor_mv  = '0;
            margin    = 16'd200;
            unclamped = 1'b1;
            limit_on  = 1'b0;
            clear_windows();
        endfunction

        function void clear_windows();
            short_total = '0;
            long_total  = '0;
            short_idx   = 0;
            long_idx    = 0;
            short_ready = 1'b0;
            long_ready  = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CONTROL_ENABLE:     enable = data[0];
                REG_CHARGE_TARGET_MA:   target = data;
                REG_OUTPUT_SETPOINT_MV: setpoint = data;
                REG_MIN_OUTPUT_MV:      floor_mv = data;
                REG_RELEASE_MARGIN_MA:  margin = data;
                default: ;
            endcase
        endfunction

        function void sample_taken(logic [15:0] meas);
            limiter_word_t      w;
            int                 err_i;
            logic signed [16:0] err;
            longint             num;
            longint             q;
            longint             volts;

            samples++;
            w.limiting    = limit_on;
            w.drive_valid = 1'b0;
            w.drive_mv    = '0;
            if (enable)
            begin
                err_i = int'(target) - int'(meas);
                err   = err_i[16:0];
                if (unclamped && err_i > int'(margin))
                begin
                    limit_on   = 1'b0;
                    w.limiting = 1'b0;
                    clear_windows();
                    releases++;
                end
                else
                begin
                    limit_on   = 1'b1;
                    w.limiting = 1'b1;

                    if (short_ready)
                    begin
                        short_total = short_total - short_err[short_idx];
                    end
                    short_err[short_idx] = err;
                    short_total = short_total + err;
                    short_idx++;
                    if (short_idx == SHORT_DEPTH)
                    begin
                        short_ready = 1'b1;
                        short_idx   = 0;
                    end

                    if (long_ready)
                    begin
                        long_total = long_total - long_err[long_idx];
                    end
                    long_err[long_idx] = err;
                    long_total = long_total + err;
                    long_idx++;
                    if (long_idx == LONG_DEPTH)
                    begin
                        long_ready = 1'b1;
                        long_idx   = 0;
                    end

                    if (short_ready && long_ready)
                    begin
                        num = longint'(short_total) * GAIN_P
                            + longint'(long_total) * GAIN_I * SHORT_DEPTH;
                        if (num >= 0)
                        begin
                            volts     = longint'(setpoint);
                            unclamped = 1'b1;
                            upper_clamps++;
                        end
                        else
                        begin
                            // Integer division truncates; step down once more for a floor.
                            q = num / longint'(SHORT_DEPTH * 65536);
                            if (num % longint'(SHORT_DEPTH * 65536) != 0)
                            begin
                                q = q - 1;
                            end
                            volts = longint'(setpoint) + q;
                            if (volts < longint'(floor_mv))
                            begin
                                volts = longint'(floor_mv);
                                floor_hits++;
                            end
                            unclamped = 1'b0;
                            lower_clamps++;
                        end
                        w.drive_valid = 1'b1;
                        w.drive_mv    = volts[15:0];
                        drives++;
                    end
                end
            end
            expected_words.push_back(w);
        endfunction

        function void result_seen(limiter_word_t got);
            limiter_word_t want;

            words_checked++;
            if (expected_words.size() == 0)
            begin
                $error("result word with none expected: limiting %0d drive_valid %0d drive_mv %0d",
                       got.limiting, got.drive_valid, got.drive_mv);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (got.limiting !== want.limiting)
            begin
                $error("limiting: expected %0d, actual %0d", want.limiting, got.limiting);
                mismatches++;
            end
            if (got.drive_valid !== want.drive_valid)
            begin
                $error("drive_valid: expected %0d, actual %0d", want.drive_valid, got.drive_valid);
                mismatches++;
            end
            if (got.drive_mv !== want.drive_mv)
            begin
                $error("drive_mv: expected %0d, actual %0d", want.drive_mv, got.drive_mv);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    send_idle;
    int                    recv_stall;
    int                    cycles = 0;
    limiter_scoreboard     sb = new();

    ccl_sample_if sample_ch ();
    ccl_result_if result_ch ();

    charge_current_limit_pi dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .sample_in  (sample_ch),
        .result_out (result_ch)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("charge_current_limit_pi_tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                sb.set_reg(cfg_index, cfg_wdata);
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                sb.sample_taken(sample_ch.measured_current_ma);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                sb.result_seen({result_ch.limiting, result_ch.drive_valid, result_ch.drive_mv});
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_sample(input logic [15:0] value);
        while ($urandom_range(99) < send_idle)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid               <= 1'b1;
        sample_ch.measured_current_ma <= value;
        @(posedge clk);
        while (!sample_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.expected_words.size() != 0);
    endtask

    function automatic logic [15:0] pick_value();
        int r;

        r = $urandom_range(7);
        if (r == 0)
        begin
            return 16'h0000;
        end
        if (r == 1)
        begin
            return 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    // Mostly samples whose error stays at or under the release margin, so the
    // windows fill and drive commands follow; a few wild or releasing samples.
    function automatic logic [15:0] pick_sample(int spread);
        int r;
        int lim;
        int e;
        int m;

        r = $urandom_range(99);
        if (r < 2)
        begin
            return 16'($urandom);
        end
        if (r < 3)
        begin
            return 16'h0000;
        end
        lim = (int'(sb.margin) < spread) ? int'(sb.margin) : spread;
        e = int'($urandom_range(spread + lim)) - spread;
        m = int'(sb.target) - e;
        if (m < 0)
        begin
            m = 0;
        end
        if (m > 65535)
        begin
            m = 65535;
        end
        return m[15:0];
    endfunction

    initial
    begin
        logic [15:0] setpoint_val;
        logic [15:0] min_val;
        int          spread;

        rst_n                         = 1'b0;
        cfg_we                        = 1'b0;
        cfg_index                     = '0;
        cfg_wdata                     = '0;
        sample_ch.valid               = 1'b0;
        sample_ch.measured_current_ma = '0;
        result_ch.ready               = 1'b0;
        send_idle                     = 0;
        recv_stall                    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_sample(16'h0000);
        send_sample(16'hFFFF);
        drain();
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_CONTROL_ENABLE, 16'd1);
        write_reg(REG_OUTPUT_SETPOINT_MV, 16'hFFFF);
        write_reg(REG_MIN_OUTPUT_MV, 16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h5A5A);
        send_sample(16'hA5A5);
        drain();
        write_reg(REG_CHARGE_TARGET_MA, 16'hFFFF);
        send_sample(16'h0000);
        drain();
        write_reg(REG_RELEASE_MARGIN_MA, 16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        drain();
        write_reg(REG_RELEASE_MARGIN_MA, 16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'hFFFE);
        drain();
        write_reg(REG_CONTROL_ENABLE, 16'd0);
        send_sample(16'd1234);
        drain();
        write_reg(REG_CONTROL_ENABLE, 16'd1);
        write_reg(REG_MIN_OUTPUT_MV, 16'h0000);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 63;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 63;
                end
                default:
                begin
                    send_idle  = 14;
                    recv_stall = 14;
                end
            endcase
            setpoint_val = pick_value();
            if ($urandom_range(3) != 0)
            begin
                min_val = 16'($urandom_range(setpoint_val));
            end
            else
            begin
                min_val = pick_value();
            end
            write_reg(REG_CHARGE_TARGET_MA, pick_value());
            write_reg(REG_OUTPUT_SETPOINT_MV, setpoint_val);
            write_reg(REG_MIN_OUTPUT_MV, min_val);
            if ($urandom_range(1) != 0)
            begin
                write_reg(REG_RELEASE_MARGIN_MA, pick_value());
            end
            else
            begin
                write_reg(REG_RELEASE_MARGIN_MA, 16'($urandom_range(2000)));
            end
            case ($urandom_range(2))
                0:       spread = 50;
                1:       spread = 600;
                default: spread = 5000;
            endcase

            if (p == RANDOM_PHASES - 2)
            begin
                write_reg(REG_CONTROL_ENABLE, 16'd0);
                for (int i = 0; i < 30; i++)
                begin
                    send_sample(16'($urandom));
                end
                drain();
                write_reg(REG_CONTROL_ENABLE, 16'd1);
            end

            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                send_sample(pick_sample(spread));
            end
            drain();
        end

        repeat (12) @(posedge clk);

        $display("Checked %0d result words for %0d samples; %0d drive commands, %0d at the",
                 sb.words_checked, sb.samples, sb.drives, sb.upper_clamps);
        $display("setpoint and %0d below it (%0d raised to the minimum); %0d releases.",
                 sb.lower_clamps, sb.floor_hits, sb.releases);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0)
        begin
            $display("charge_current_limit_pi_tb: done, clean");
        end
        else
        begin
            $display("charge_current_limit_pi_tb: done, errors");
        end
        $finish;
    end
endmodule

// ===== charge_current_limit_pi.f =====
rtl/ccl_pkg.sv
rtl/ccl_sample_if.sv
rtl/ccl_result_if.sv
rtl/ccl_drive_stage.sv
rtl/charge_current_limit_pi.sv
tb/sv/charge_current_limit_pi_tb.sv
